@@ design/packed_decimal_to_ascii_unit_assert.svh @@
// Assertion macros shared by the checker of the packed-decimal to ASCII unit.
// Needs nothing else; the including file supplies clock, reset and signals.
`ifndef PACKED_DECIMAL_TO_ASCII_UNIT_ASSERT_SVH
`define PACKED_DECIMAL_TO_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PDTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pdta_pkg.sv @@
// Package for the packed-decimal to ASCII unit: widths, character codes,
// register indexes, controller states and the controller/datapath structs.
package pdta_pkg;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int VAL_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int CHAR_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 1'b1;

  localparam logic [NIB_W-1:0]  SIGN_NEG    = 4'hD;
  localparam logic [NIB_W-1:0]  DIGIT_ZERO  = 4'h0;
  localparam logic [NIB_W-1:0]  DIGIT_HIGH  = 4'h3;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT  = 8'h2E;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_t;

  typedef enum logic [1:0] {
    CH_MINUS,
    CH_POINT,
    CH_DIGIT
  } char_sel_t;

  typedef struct packed {
    logic      cfg_en;
    logic      load;
    logic      emit;
    char_sel_t char_sel;
    logic      emit_last;
    logic      step;
    logic      clear_skip;
  } cmd_t;

  typedef struct packed {
    logic final_byte;
    logic negative;
    logic skip_zero;
    logic int_last;
    logic frac_last;
    logic has_frac;
    logic out_free;
  } status_t;

endpackage

@@ design/pdta_ctrl.sv @@
// Controller of the packed-decimal to ASCII unit: sequences byte loading and
// character emission. Depends on pdta_pkg.
module pdta_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pdta_pkg::status_t st,
  output pdta_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              cfg_ready
);
  import pdta_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.cfg_en     = 1'b0;
    cmd.load       = 1'b0;
    cmd.emit       = 1'b0;
    cmd.char_sel   = CH_DIGIT;
    cmd.emit_last  = 1'b0;
    cmd.step       = 1'b0;
    cmd.clear_skip = 1'b0;
    in_stall       = 1'b1;
    cfg_ready      = 1'b0;
    case (state)
      ST_LOAD: begin
        in_stall   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.cfg_en = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.final_byte) begin
            state_next = ST_SIGN;
          end
        end
      end
      ST_SIGN: begin
        if (!st.negative) begin
          state_next = ST_INT;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CH_MINUS;
          state_next   = ST_INT;
        end
      end
      ST_INT: begin
        if (st.skip_zero) begin
          cmd.step = 1'b1;
        end else if (st.out_free) begin
          cmd.emit       = 1'b1;
          cmd.char_sel   = CH_DIGIT;
          cmd.emit_last  = st.int_last && !st.has_frac;
          cmd.step       = 1'b1;
          cmd.clear_skip = 1'b1;
          if (st.int_last) begin
            state_next = st.has_frac ? ST_POINT : ST_LOAD;
          end
        end
      end
      ST_POINT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CH_POINT;
          state_next   = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.char_sel  = CH_DIGIT;
          cmd.emit_last = st.frac_last;
          cmd.step      = 1'b1;
          if (st.frac_last) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

@@ design/pdta_datapath.sv @@
// Datapath of the packed-decimal to ASCII unit: configuration registers,
// byte store, digit index and output register. Depends on pdta_pkg.
module pdta_datapath #(
  parameter int MAX_DIGITS = 31
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pdta_pkg::cmd_t                     cmd,
  output pdta_pkg::status_t                  st,
  input  logic [pdta_pkg::BYTE_W-1:0]        packed_byte,
  input  logic                               cfg_valid,
  input  logic [pdta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdta_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [pdta_pkg::CHAR_W-1:0]        text_char,
  output logic                               last_char
);
  import pdta_pkg::*;

  localparam int NBYTES_MAX = (MAX_DIGITS + 2) / 2;
  localparam int BA_W       = (NBYTES_MAX > 1) ? $clog2(NBYTES_MAX) : 1;

  logic [CFG_W-1:0]  precision;
  logic [CFG_W-1:0]  scale;
  logic [BYTE_W-1:0] byte_mem [NBYTES_MAX];
  logic [BA_W-1:0]   byte_count;
  logic              negative;
  logic [VAL_W-1:0]  idx;
  logic              skipping;

  logic [VAL_W-1:0]  p_ext;
  logic [VAL_W-1:0]  p_eff;
  logic [VAL_W-1:0]  sc_ext;
  logic [VAL_W-1:0]  sc_eff;
  logic [VAL_W-1:0]  nbytes;
  logic [VAL_W-1:0]  ndig;
  logic [VAL_W-1:0]  intd;
  logic [VAL_W-1:0]  idx_inc;
  logic [BYTE_W-1:0] byte_sel;
  logic [NIB_W-1:0]  digit;
  logic              final_byte;
  logic              out_free;
  logic [CHAR_W-1:0] char_next;

  always_comb begin
    p_ext = VAL_W'(precision);
    if (p_ext == '0) begin
      p_eff = VAL_W'(1);
    end else if (p_ext > VAL_W'(MAX_DIGITS)) begin
      p_eff = VAL_W'(MAX_DIGITS);
    end else begin
      p_eff = p_ext;
    end
    sc_ext = VAL_W'(scale);
    if (sc_ext > p_eff - VAL_W'(1)) begin
      sc_eff = p_eff - VAL_W'(1);
    end else begin
      sc_eff = sc_ext;
    end
    nbytes = (p_eff + VAL_W'(2)) >> 1;
    ndig   = (nbytes << 1) - VAL_W'(1);
    intd   = ndig - sc_eff;
  end

  assign idx_inc    = idx + VAL_W'(1);
  assign byte_sel   = byte_mem[idx[BA_W:1]];
  assign digit      = idx[0] ? byte_sel[NIB_W-1:0] : byte_sel[BYTE_W-1:NIB_W];
  assign final_byte = (VAL_W'(byte_count) + VAL_W'(1)) >= nbytes;
  assign out_free   = !out_valid || !out_stall;

  assign st.final_byte = final_byte;
  assign st.negative   = negative;
  assign st.skip_zero  = skipping && (digit == DIGIT_ZERO) && (idx_inc < intd);
  assign st.int_last   = idx_inc == intd;
  assign st.frac_last  = idx_inc == ndig;
  assign st.has_frac   = sc_eff != '0;
  assign st.out_free   = out_free;

  always_comb begin
    case (cmd.char_sel)
      CH_MINUS: char_next = CHAR_MINUS;
      CH_POINT: char_next = CHAR_POINT;
      CH_DIGIT: char_next = CHAR_ZERO | CHAR_W'(digit);
      default:  char_next = CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_mem[byte_count] <= packed_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      precision  <= CFG_W'(1);
      scale      <= '0;
      byte_count <= '0;
      negative   <= 1'b0;
      idx        <= '0;
      skipping   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.cfg_en && cfg_valid) begin
        case (cfg_index)
          CFG_PRECISION: precision <= cfg_data;
          CFG_SCALE:     scale     <= cfg_data;
          default:       scale     <= scale;
        endcase
        byte_count <= '0;
      end else if (cmd.load) begin
        if (final_byte) begin
          byte_count <= '0;
          negative   <= packed_byte[NIB_W-1:0] == SIGN_NEG;
          idx        <= '0;
          skipping   <= 1'b1;
        end else begin
          byte_count <= byte_count + BA_W'(1);
        end
      end
      if (cmd.step) begin
        idx <= idx_inc;
      end
      if (cmd.clear_skip) begin
        skipping <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      text_char <= char_next;
      last_char <= cmd.emit_last;
    end
  end

endmodule

@@ design/packed_decimal_to_ascii_unit.sv @@
// Packed-decimal to ASCII unit: one byte per cycle is taken until the last byte of a value,
// then its text comes out through a registered output stage, and no byte is taken until
// the last character has been emitted. After the last byte, a negative value first emits a
// minus sign; leading zeros of the integer part are then dropped before the first digit.
// Reset (rst, synchronous): precision 1, scale 0, output empty.
module packed_decimal_to_ascii_unit #(
  parameter int MAX_DIGITS = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pdta_pkg::BYTE_W-1:0]    packed_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pdta_pkg::CHAR_W-1:0]    text_char,
  output logic                           last_char,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdta_pkg::CFG_W-1:0]     cfg_data
);
  import pdta_pkg::*;

  cmd_t    cmd;
  status_t st;

  pdta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .st        (st),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  pdta_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .packed_byte (packed_byte),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .text_char   (text_char),
    .last_char   (last_char)
  );

endmodule

@@ design/pdta_checker.sv @@
// Port-level checker for the packed-decimal to ASCII unit, bound to the top level.
// Depends on pdta_pkg and packed_decimal_to_ascii_unit_assert.svh.
`include "packed_decimal_to_ascii_unit_assert.svh"

module pdta_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pdta_pkg::CHAR_W-1:0]    text_char,
  input logic                           last_char,
  input logic                           cfg_ready
);
  import pdta_pkg::*;

  `PDTA_ASSERT_NOW(a_mid_string_stalls, clk, rst, out_valid && !last_char, in_stall, "input taken while a string is still being emitted")

  `PDTA_ASSERT_NOW(a_cfg_only_idle, clk, rst, cfg_ready, !in_stall, "configuration offered while the unit is busy")

  `PDTA_ASSERT_NOW(a_char_legal, clk, rst, out_valid, (text_char[CHAR_W-1:NIB_W] == DIGIT_HIGH) || (text_char == CHAR_MINUS) || (text_char == CHAR_POINT), "character outside the decoded set")

  `PDTA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(text_char) && $stable(last_char), "stalled output changed")

endmodule

bind packed_decimal_to_ascii_unit pdta_checker u_pdta_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .text_char (text_char),
  .last_char (last_char),
  .cfg_ready (cfg_ready)
);

@@ tb/pdta_text_checker.sv @@
// Checker for the packed-decimal to ASCII unit: watches the byte, character and
// register channels, predicts the text of each value and compares it per transfer.
// Depends on pdta_pkg for widths, register indexes and character codes.
module pdta_text_checker
  import pdta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    packed_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CHAR_W-1:0]    text_char,
  input  logic                 last_char,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   chars_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIGITS = 31;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_item_t;

  text_item_t       chars_due[$];
  logic [NIB_W-1:0] nibbles[0:MAX_DIGITS+1];
  logic [CFG_W-1:0] precision;
  logic [CFG_W-1:0] scale;
  logic [4:0]       byte_count;
  logic             negative;

  initial begin
    mismatches = 0;
    chars_owed = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void push_char(input logic [CHAR_W-1:0] ch);
    chars_due.push_back('{ch: ch, last: 1'b0});
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    int prec, nbytes, frac, ndig, intd, lead, i;
    prec = (precision == 0) ? 1 : int'(precision);
    if (prec > MAX_DIGITS) prec = MAX_DIGITS;
    nbytes = (prec + 2) / 2;
    frac = (int'(scale) > prec - 1) ? prec - 1 : int'(scale);
    if (int'(byte_count) + 1 < nbytes) begin
      nibbles[2 * byte_count]     = b[7:4];
      nibbles[2 * byte_count + 1] = b[3:0];
      byte_count++;
      return;
    end
    nibbles[2 * (nbytes - 1)] = b[7:4];
    negative = (b[3:0] == SIGN_NEG);
    byte_count = '0;
    ndig = 2 * nbytes - 1;
    intd = ndig - frac;
    lead = 0;
    while (lead + 1 < intd && nibbles[lead] == DIGIT_ZERO) lead++;
    if (negative) push_char(CHAR_MINUS);
    for (i = lead; i < intd; i++) push_char(CHAR_ZERO | {4'h0, nibbles[i]});
    if (frac > 0) begin
      push_char(CHAR_POINT);
      for (i = intd; i < ndig; i++) push_char(CHAR_ZERO | {4'h0, nibbles[i]});
    end
    chars_due[chars_due.size() - 1].last = 1'b1;
  endtask

  task automatic check_char();
    text_item_t want;
    if (chars_due.size() == 0) begin
      report_mismatch("character with nothing due", text_char, 0);
      return;
    end
    want = chars_due.pop_front();
    if (text_char !== want.ch) report_mismatch("text_char", text_char, want.ch);
    if (last_char !== want.last) report_mismatch("last_char", last_char, want.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      precision = 5'd1;
      scale = '0;
      byte_count = '0;
      negative = 1'b0;
      chars_due.delete();
    end else begin
      if (out_valid && !out_stall) check_char();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRECISION: begin
            precision = cfg_data;
            byte_count = '0;
          end
          CFG_SCALE: begin
            scale = cfg_data;
            byte_count = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(packed_byte);
    end
    chars_owed = chars_due.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the testbench for the packed-decimal to ASCII unit: drives bytes, register
// writes and output stalls, then gives the verdict from the checker's mismatch count.
// Depends on pdta_pkg, packed_decimal_to_ascii_unit and pdta_text_checker.
module tb_top;
  import pdta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [NIB_W-1:0] SIGN_PLUS     = 4'hC;
  localparam logic [NIB_W-1:0] SIGN_UNSIGNED = 4'hF;
  localparam int               SETTLE_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    packed_byte;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    text_char;
  logic                 last_char;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   chars_owed;

  bit idling;
  int stall_left;
  int bytes_sent;
  int value_bytes;

  always #1 clk = ~clk;

  packed_decimal_to_ascii_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .packed_byte(packed_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .text_char(text_char), .last_char(last_char),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pdta_text_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .packed_byte(packed_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .text_char(text_char), .last_char(last_char),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .chars_owed(chars_owed)
  );

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idling && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
    out_stall <= (stall_left > 0);
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_valid = 1'b1;
    packed_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (idling && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (chars_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_PRECISION) value_bytes = (((val == 0) ? 1 : int'(val)) + 2) / 2;
  endtask

  function automatic logic [NIB_W-1:0] pick_digit(input int pos, input int zeros,
                                                  input bit wild);
    if (pos < zeros) return DIGIT_ZERO;
    return wild ? NIB_W'($urandom_range(0, 15)) : NIB_W'($urandom_range(0, 9));
  endfunction

  task automatic send_value();
    int zeros, k;
    bit wild;
    logic [NIB_W-1:0] sign;
    zeros = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2 * value_bytes - 1) : 0;
    wild = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 3))
      0: sign = SIGN_PLUS;
      1: sign = SIGN_NEG;
      2: sign = SIGN_UNSIGNED;
      default: sign = NIB_W'($urandom_range(0, 15));
    endcase
    for (k = 0; k < value_bytes; k++) begin
      if (k == value_bytes - 1) send_byte({pick_digit(2 * k, zeros, wild), sign});
      else send_byte({pick_digit(2 * k, zeros, wild), pick_digit(2 * k + 1, zeros, wild)});
    end
  endtask

  initial begin
    int phase, prec, frac, n;
    rst = 1'b1;
    in_valid = 1'b0;
    packed_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PRECISION;
    cfg_data = '0;
    idling = 1'b0;
    stall_left = 0;
    bytes_sent = 0;
    value_bytes = 1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    idling = 1'b1;
    send_byte({4'h5, SIGN_PLUS});
    send_byte({4'h0, SIGN_NEG});
    send_byte({4'hF, SIGN_UNSIGNED});
    send_byte({4'hA, SIGN_NEG});
    wait_idle();
    write_reg(CFG_PRECISION, 5'd0);
    write_reg(CFG_SCALE, 5'd31);
    send_byte(8'h00);
    send_byte(8'h9B);
    wait_idle();
    write_reg(CFG_PRECISION, 5'd3);
    write_reg(CFG_SCALE, 5'd2);
    send_byte(8'h00);
    send_byte({4'h0, SIGN_NEG});
    send_byte(8'h12);
    send_byte({4'h3, SIGN_PLUS});
    wait_idle();
    write_reg(CFG_PRECISION, 5'd4);
    write_reg(CFG_SCALE, 5'd0);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte({4'h1, SIGN_PLUS});
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte({4'h0, SIGN_NEG});
    send_byte(8'h99);
    wait_idle();
    write_reg(CFG_SCALE, 5'd0);
    send_byte(8'h70);
    send_byte(8'h08);
    send_byte({4'h9, SIGN_UNSIGNED});

    phase = 0;
    while (bytes_sent < 215) begin
      case (phase)
        0: begin prec = 31; frac = 30; end
        1: begin prec = 31; frac = 0; end
        2: begin prec = 2; frac = 31; end
        3: begin prec = 0; frac = 5; end
        default: begin
          prec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
          frac = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, prec);
        end
      endcase
      idling = (bytes_sent < 175) && ($urandom_range(0, 3) != 0);
      if (value_bytes > 1 && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, value_bytes - 1);
        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
      wait_idle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_PRECISION, CFG_W'(prec));
        write_reg(CFG_SCALE, CFG_W'(frac));
      end else begin
        write_reg(CFG_SCALE, CFG_W'(frac));
        write_reg(CFG_PRECISION, CFG_W'(prec));
      end
      repeat ($urandom_range(2, 5)) send_value();
      phase++;
    end

    idling = 1'b0;
    wait_idle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
